[hw/rtl/ntcd_pkg.sv]
package ntcd_pkg;

    // request codes
    localparam logic [1:0] REQ_CLEAR = 2'd0;
    localparam logic [1:0] REQ_ADD   = 2'd1;
    localparam logic [1:0] REQ_QUERY = 2'd2;

    // field widths
    localparam int unsigned POS_W    = 15;
    localparam int unsigned SIZE_W   = 14;
    localparam int unsigned BOX_W    = 2 * POS_W + 2 * SIZE_W;
    localparam int unsigned TRK_OUT_W = 6;
    localparam int unsigned DIST_W   = 34;

    // controller -> datapath
    typedef struct packed {
        logic clear;
        logic append;
        logic load_query;
        logic scan_step;
    } ntcd_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic scan_last;
        logic pipe_busy;
    } ntcd_status_t;

endpackage

[hw/rtl/ntcd_datapath.sv]
module ntcd_datapath
    import ntcd_pkg::*;
#(
    parameter int unsigned MAX_TRACKS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  ntcd_cmd_t                cmd,
    output ntcd_status_t             status,
    input  logic signed [POS_W-1:0]  box_x,
    input  logic signed [POS_W-1:0]  box_y,
    input  logic [SIZE_W-1:0]        box_w,
    input  logic [SIZE_W-1:0]        box_h,
    output logic                     match_found,
    output logic [TRK_OUT_W-1:0]     best_track,
    output logic [DIST_W-1:0]        best_dist_sq
);

    localparam int unsigned AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int unsigned CW = $clog2(MAX_TRACKS + 1);

    // track store
    logic [BOX_W-1:0] mem [MAX_TRACKS];
    logic [CW-1:0]    count_reg;
    logic             full;

    // query box, bottom-right corner precomputed
    logic signed [POS_W-1:0] q_x_reg;
    logic signed [POS_W-1:0] q_y_reg;
    logic signed [POS_W:0]   q_r_reg;
    logic signed [POS_W:0]   q_b_reg;

    logic [AW-1:0] idx_reg;

    // stage 0: read data
    logic             v0_reg;
    logic [AW-1:0]    i0_reg;
    logic [BOX_W-1:0] rd_reg;
    // stage 1: absolute differences
    logic             v1_reg;
    logic [AW-1:0]    i1_reg;
    logic [POS_W-1:0] ax_reg, ay_reg;
    logic [POS_W:0]   ar_reg, ab_reg;
    // stage 2: squares
    logic                 v2_reg;
    logic [AW-1:0]        i2_reg;
    logic [2*POS_W-1:0]   sqx_reg, sqy_reg;
    logic [2*POS_W+1:0]   sqr_reg, sqb_reg;
    // stage 3: pair sums
    logic                 v3_reg;
    logic [AW-1:0]        i3_reg;
    logic [2*POS_W:0]     s0_reg;
    logic [2*POS_W+2:0]   s1_reg;
    // stage 4: total
    logic                 v4_reg;
    logic [AW-1:0]        i4_reg;
    logic [DIST_W-1:0]    tot_reg;

    logic                 found_reg;
    logic [AW-1:0]        best_idx_reg;
    logic [DIST_W-1:0]    best_reg;

    logic signed [POS_W-1:0] t_x, t_y;
    logic [SIZE_W-1:0]       t_w, t_h;
    logic signed [POS_W:0]   t_r, t_b;
    logic signed [POS_W:0]   dx, dy;
    logic signed [POS_W+1:0] dr, db;
    logic [POS_W-1:0]        ax_next, ay_next;
    logic [POS_W:0]          ar_next, ab_next;
    logic                    take;

    assign full = (count_reg == CW'(MAX_TRACKS));

    assign status.empty     = (count_reg == '0);
    assign status.scan_last = (CW'(idx_reg) == count_reg - CW'(1));
    assign status.pipe_busy = v0_reg | v1_reg | v2_reg | v3_reg | v4_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.append && !full)
        begin
            mem[count_reg[AW-1:0]] <= {box_x, box_y, box_w, box_h};
        end
        if (cmd.scan_step)
        begin
            rd_reg <= mem[idx_reg];
        end
    end

    assign {t_x, t_y, t_w, t_h} = rd_reg;

    always_comb
    begin
        t_r = (POS_W+1)'(t_x) + $signed({2'b00, t_w});
        t_b = (POS_W+1)'(t_y) + $signed({2'b00, t_h});
        dx  = (POS_W+1)'(q_x_reg) - (POS_W+1)'(t_x);
        dy  = (POS_W+1)'(q_y_reg) - (POS_W+1)'(t_y);
        dr  = (POS_W+2)'(q_r_reg) - (POS_W+2)'(t_r);
        db  = (POS_W+2)'(q_b_reg) - (POS_W+2)'(t_b);
        ax_next = dx[POS_W]   ? POS_W'(-dx)     : POS_W'(dx);
        ay_next = dy[POS_W]   ? POS_W'(-dy)     : POS_W'(dy);
        ar_next = dr[POS_W+1] ? (POS_W+1)'(-dr) : (POS_W+1)'(dr);
        ab_next = db[POS_W+1] ? (POS_W+1)'(-db) : (POS_W+1)'(db);
        take = v4_reg && (!found_reg || (tot_reg < best_reg));
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            q_x_reg <= box_x;
            q_y_reg <= box_y;
            q_r_reg <= (POS_W+1)'(box_x) + $signed({2'b00, box_w});
            q_b_reg <= (POS_W+1)'(box_y) + $signed({2'b00, box_h});
        end
        i0_reg  <= idx_reg;
        i1_reg  <= i0_reg;
        ax_reg  <= ax_next;
        ay_reg  <= ay_next;
        ar_reg  <= ar_next;
        ab_reg  <= ab_next;
        i2_reg  <= i1_reg;
        sqx_reg <= {{POS_W{1'b0}}, ax_reg} * {{POS_W{1'b0}}, ax_reg};
        sqy_reg <= {{POS_W{1'b0}}, ay_reg} * {{POS_W{1'b0}}, ay_reg};
        sqr_reg <= {{(POS_W+1){1'b0}}, ar_reg} * {{(POS_W+1){1'b0}}, ar_reg};
        sqb_reg <= {{(POS_W+1){1'b0}}, ab_reg} * {{(POS_W+1){1'b0}}, ab_reg};
        i3_reg  <= i2_reg;
        s0_reg  <= (2*POS_W+1)'(sqx_reg) + (2*POS_W+1)'(sqy_reg);
        s1_reg  <= (2*POS_W+3)'(sqr_reg) + (2*POS_W+3)'(sqb_reg);
        i4_reg  <= i3_reg;
        tot_reg <= DIST_W'(s0_reg) + DIST_W'(s1_reg);
        if (cmd.load_query)
        begin
            best_idx_reg <= '0;
            best_reg     <= '0;
        end
        else if (take)
        begin
            best_idx_reg <= i4_reg;
            best_reg     <= tot_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append && !full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.load_query)
            begin
                idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + AW'(1);
            end
            v0_reg <= cmd.scan_step;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.load_query)
            begin
                found_reg <= 1'b0;
            end
            else if (v4_reg)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    assign match_found  = found_reg;
    assign best_track   = TRK_OUT_W'(best_idx_reg);
    assign best_dist_sq = best_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_TRACKS))
        else $error("track count above capacity");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (CW'(idx_reg) < count_reg))
        else $error("scan reads beyond stored tracks");

    a_first_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (v4_reg && !found_reg) |-> (i4_reg == '0))
        else $error("first compared track is not index zero");
`endif

endmodule

[hw/rtl/ntcd_ctrl.sv]
module ntcd_ctrl
    import ntcd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [1:0]   req_type,
    output logic         busy,
    output logic         done,
    output ntcd_cmd_t    cmd,
    input  ntcd_status_t status
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    logic   done_reg;
    logic   accept;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_CLEAR: cmd.clear      = 1'b1;
                        REQ_ADD:   cmd.append     = 1'b1;
                        REQ_QUERY: cmd.load_query = 1'b1;
                        default:   cmd = '0;
                    endcase
                end
            end
            ST_SCAN:  cmd.scan_step = 1'b1;
            ST_DRAIN: cmd = '0;
            default:  cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load_query)
                    begin
                        if (status.empty)
                        begin
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (status.scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (!status.pipe_busy)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (state_reg == ST_IDLE))
        else $error("result strobe while busy");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !status.empty)
        else $error("scan of an empty table");

    a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && !status.pipe_busy) |=> done_reg)
        else $error("drained query gave no result");
`endif

endmodule

[hw/rtl/nearest_track_by_corner_distance_core.sv]
// Channel   Handshake          Fields                                      Width
// -------   ----------------   -----------------------------------------   -----
// request   start & !busy      req_type, box_x, box_y, box_w, box_h        2/15/15/14/14
// result    done (1 cycle)     match_found, best_track, best_dist_sq       1/6/34
//
// Operation: clear and append give no result. A query on a
//   non-empty table scans one stored track per cycle through the single read
//   port of the track memory, then drains the 5-stage distance pipeline:
//   done rises once the pipeline has emptied, and busy drops with it.
//   An empty-table query gives its result the cycle after the request beat.
// Reset: rst_n clears the track count and control; table contents stay unknown.
// Stalls: the receiver cannot hold off a result beat; done lasts one cycle.
module nearest_track_by_corner_distance_core
    import ntcd_pkg::*;
#(
    parameter int unsigned MAX_TRACKS = 64
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               req_type,
    input  logic signed [POS_W-1:0]  box_x,
    input  logic signed [POS_W-1:0]  box_y,
    input  logic [SIZE_W-1:0]        box_w,
    input  logic [SIZE_W-1:0]        box_h,
    output logic                     done,
    output logic                     match_found,
    output logic [TRK_OUT_W-1:0]     best_track,
    output logic [DIST_W-1:0]        best_dist_sq
);

    ntcd_cmd_t    cmd;
    ntcd_status_t status;

    // sequencer: request decode, scan and drain control
    ntcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (req_type),
        .busy     (busy),
        .done     (done),
        .cmd      (cmd),
        .status   (status)
    );

    // track memory, distance pipeline and running minimum
    ntcd_datapath #(
        .MAX_TRACKS (MAX_TRACKS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .box_x        (box_x),
        .box_y        (box_y),
        .box_w        (box_w),
        .box_h        (box_h),
        .match_found  (match_found),
        .best_track   (best_track),
        .best_dist_sq (best_dist_sq)
    );

endmodule

[tb/sv/tb_nearest_track_by_corner_distance_core.sv]
module tb_nearest_track_by_corner_distance_core;
    import ntcd_pkg::*;

    localparam int          TRACK_CAP    = 64;
    localparam int          ITEM_BUDGET  = 1550;
    localparam int          DRAIN_CYCLES = 80;    // covers a full-table scan and drain, plus margin
    localparam logic [1:0]  REQ_UNUSED   = 2'd3;  // block must ignore this code

    // one request beat: code plus detection/track box
    typedef struct {
        logic [1:0]               req;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [SIZE_W-1:0]        w;
        logic [SIZE_W-1:0]        h;
    } box_req_t;

    // one result beat
    typedef struct {
        logic                  found;
        logic [TRK_OUT_W-1:0]  track;
        logic [DIST_W-1:0]     dist_sq;
    } match_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic [1:0]               req_type = REQ_CLEAR;
    logic signed [POS_W-1:0]  box_x = '0;
    logic signed [POS_W-1:0]  box_y = '0;
    logic [SIZE_W-1:0]        box_w = '0;
    logic [SIZE_W-1:0]        box_h = '0;
    logic                     done;
    logic                     match_found;
    logic [TRK_OUT_W-1:0]     best_track;
    logic [DIST_W-1:0]        best_dist_sq;

    nearest_track_by_corner_distance_core #(
        .MAX_TRACKS(TRACK_CAP)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .req_type(req_type),
        .box_x(box_x),
        .box_y(box_y),
        .box_w(box_w),
        .box_h(box_h),
        .done(done),
        .match_found(match_found),
        .best_track(best_track),
        .best_dist_sq(best_dist_sq)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 0;
    end

    // ---------------------------------------------------------------
    // Shadow track table, updated on every accepted request beat
    // ---------------------------------------------------------------
    box_req_t  track_boxes [TRACK_CAP];
    int        track_total = 0;

    box_req_t  pending_beats [$];      // waiting to be driven
    match_t    expected_matches [$];   // predicted results, oldest first
    int        fail_count = 0;
    logic      beat_taken = 1'b0;      // a request beat was accepted at the last rising edge

    // sum of squared differences of top-left and bottom-right corners
    function automatic longint corner_dist(box_req_t a, box_req_t b);
        longint dx0, dy0, dx1, dy1;
        dx0 = longint'(a.x) - longint'(b.x);
        dy0 = longint'(a.y) - longint'(b.y);
        dx1 = (longint'(a.x) + longint'(a.w)) - (longint'(b.x) + longint'(b.w));
        dy1 = (longint'(a.y) + longint'(a.h)) - (longint'(b.y) + longint'(b.h));
        return dx0 * dx0 + dy0 * dy0 + dx1 * dx1 + dy1 * dy1;
    endfunction

    // scan in index order; strict less-than keeps the lowest index on ties
    function automatic match_t nearest_match(box_req_t q);
        match_t  m;
        longint  d;
        m.found   = 1'b0;
        m.track   = '0;
        m.dist_sq = '0;
        for (int i = 0; i < track_total; i++)
        begin
            d = corner_dist(q, track_boxes[i]);
            if (i == 0 || d < longint'(m.dist_sq))
            begin
                m.found   = 1'b1;
                m.track   = i[TRK_OUT_W-1:0];
                m.dist_sq = d[DIST_W-1:0];
            end
        end
        return m;
    endfunction

    task automatic apply_request(box_req_t r);
        case (r.req)
            REQ_CLEAR: track_total = 0;
            REQ_ADD:
            begin
                // appends to a full table are dropped
                if (track_total < TRACK_CAP)
                begin
                    track_boxes[track_total] = r;
                    track_total++;
                end
            end
            REQ_QUERY: expected_matches.push_back(nearest_match(r));
            default: ;   // unused code: no result, no state change
        endcase
    endtask

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $realtime, msg);
    endtask

    // ---------------------------------------------------------------
    // Monitor: checks result beats, predicts on accepted request beats
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor_proc
        match_t    got;
        match_t    want;
        box_req_t  r;
        if (rst_n && done)
        begin
            got.found   = match_found;
            got.track   = best_track;
            got.dist_sq = best_dist_sq;
            if (expected_matches.size() == 0)
                note_failure($sformatf(
                    "result beat with none expected: found=%0b track=%0d dist=%0d",
                    got.found, got.track, got.dist_sq));
            else
            begin
                want = expected_matches.pop_front();
                if (got.found !== want.found || got.track !== want.track
                    || got.dist_sq !== want.dist_sq)
                    note_failure($sformatf(
                        {"result mismatch: exp found=%0b track=%0d dist=%0d, ",
                         "got found=%0b track=%0d dist=%0d"},
                        want.found, want.track, want.dist_sq,
                        got.found, got.track, got.dist_sq));
            end
        end
        // request beat: start high while not busy; fields are stable since the falling edge
        if (rst_n && start && !busy)
        begin
            r.req = req_type;
            r.x   = box_x;
            r.y   = box_y;
            r.w   = box_w;
            r.h   = box_h;
            apply_request(r);
            if (pending_beats.size() != 0)
                void'(pending_beats.pop_front());
            beat_taken <= 1'b1;
        end
        else
            beat_taken <= 1'b0;
    end

    // ---------------------------------------------------------------
    // Driver: bursts of beats with random gaps, changes on falling edge
    // ---------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge clk)
    begin : driver_proc
        logic go;
        go = 1'b0;
        if (beat_taken)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                burst_left = $urandom_range(1, 20);
                // mostly back-to-back, sometimes gaps long enough to span a scan
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: gap_left = 0;
                    4, 5, 6, 7: gap_left = $urandom_range(1, 8);
                    8:          gap_left = $urandom_range(10, 40);
                    default:    gap_left = $urandom_range(40, 90);
                endcase
            end
        end
        if (gap_left > 0)
            gap_left--;
        else
            go = rst_n && (pending_beats.size() != 0);
        start <= go;
        if (go)
        begin
            req_type <= pending_beats[0].req;
            box_x    <= pending_beats[0].x;
            box_y    <= pending_beats[0].y;
            box_w    <= pending_beats[0].w;
            box_h    <= pending_beats[0].h;
        end
        else
        begin
            // junk on the fields while start is low
            req_type <= 2'($urandom);
            box_x    <= 15'($urandom);
            box_y    <= 15'($urandom);
            box_w    <= 14'($urandom);
            box_h    <= 14'($urandom);
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    int        gen_total = 0;    // track count as seen by the generator
    int        budget_used = 0;  // beats that the block acts on
    box_req_t  added_boxes [$];  // recent track boxes, reused for exact hits and ties

    task automatic push_beat(logic [1:0] req, int x, int y, int w, int h);
        box_req_t r;
        r.req = req;
        r.x   = x[POS_W-1:0];
        r.y   = y[POS_W-1:0];
        r.w   = w[SIZE_W-1:0];
        r.h   = h[SIZE_W-1:0];
        pending_beats.push_back(r);
        case (req)
            REQ_CLEAR:
            begin
                gen_total = 0;
                budget_used++;
            end
            REQ_ADD:
            begin
                if (gen_total < TRACK_CAP)
                begin
                    gen_total++;
                    budget_used++;
                end
                added_boxes.push_back(r);
                if (added_boxes.size() > TRACK_CAP)
                    void'(added_boxes.pop_front());
            end
            REQ_QUERY: budget_used++;
            default: ;
        endcase
    endtask

    task automatic push_random(logic [1:0] req);
        box_req_t b;
        int       sel;
        sel = $urandom_range(0, 5);
        if (sel == 5 && added_boxes.size() == 0)
            sel = 0;
        case (sel)
            0, 1, 2:
                push_beat(req, $urandom, $urandom, $urandom, $urandom);
            3:  // tiny coordinates: many equal distances
                push_beat(req, $urandom_range(0, 4) - 2, $urandom_range(0, 4) - 2,
                          $urandom_range(0, 2), $urandom_range(0, 2));
            4:  // field extremes
                push_beat(req, $urandom_range(0, 1) ? -16384 : 16383,
                          $urandom_range(0, 1) ? -16384 : 16383,
                          $urandom_range(0, 1) ? 16383 : 0,
                          $urandom_range(0, 1) ? 16383 : 0);
            default:
            begin
                // repeat a recent track: duplicate add or zero-distance query
                b = added_boxes[$urandom_range(0, added_boxes.size() - 1)];
                push_beat(req, b.x, b.y, b.w, b.h);
            end
        endcase
    endtask

    task automatic wait_idle();
        while (pending_beats.size() != 0 || expected_matches.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin : stimulus_proc
        int   n_add;
        int   n_query;
        bit   first;
        bit   paused;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        push_beat(REQ_QUERY, 5, 5, 5, 5);                   // empty table
        push_beat(REQ_UNUSED, 100, -100, 7, 7);             // ignored code
        push_beat(REQ_ADD, -16384, -16384, 0, 0);
        push_beat(REQ_ADD, -16384, -16384, 0, 0);           // duplicate for a tie
        push_beat(REQ_ADD, 16383, 16383, 16383, 16383);
        push_beat(REQ_ADD, 0, 0, 16383, 0);
        push_beat(REQ_QUERY, 16383, 16383, 16383, 16383);   // exact hit on track 2
        push_beat(REQ_QUERY, -16384, -16384, 0, 0);         // tie between 0 and 1
        push_beat(REQ_QUERY, 16383, -16384, 0, 16383);
        push_beat(REQ_QUERY, -16384, 16383, 16383, 0);
        push_beat(REQ_UNUSED, -1, -1, 16383, 16383);
        push_beat(REQ_QUERY, 0, 0, 0, 0);
        push_beat(REQ_CLEAR, 0, 0, 0, 0);
        push_beat(REQ_QUERY, -16384, 16383, 0, 16383);      // empty after clear
        push_beat(REQ_ADD, -1, -1, 1, 1);
        push_beat(REQ_QUERY, 0, 0, 0, 0);
        push_beat(REQ_ADD, 1, 1, 1, 1);                     // equidistant second track
        push_beat(REQ_QUERY, 0, 0, 1, 1);

        // hold off until the directed results are all in
        wait_idle();

        // random sessions: optional clear, a run of appends, then queries
        first  = 1'b1;
        paused = 1'b0;
        while (budget_used < ITEM_BUDGET)
        begin
            if (first || $urandom_range(0, 3) != 0)
                push_beat(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
            if (first)
                n_add = 72;                                  // overfill past capacity
            else if ($urandom_range(0, 9) == 0)
                n_add = $urandom_range(50, 72);
            else
                n_add = $urandom_range(0, 8);
            for (int i = 0; i < n_add; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    push_random(REQ_UNUSED);
                push_random(REQ_ADD);
            end
            n_query = $urandom_range(1, 6);
            for (int i = 0; i < n_query; i++)
                push_random(REQ_QUERY);
            first = 1'b0;
            if (!paused && budget_used >= ITEM_BUDGET / 2)
            begin
                wait_idle();
                paused = 1'b1;
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog_proc
        #40000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
